[rtl/core/rpcfd_pkg.sv]
`default_nettype none
package rpcfd_pkg;

	localparam int unsigned MIN_FRAME_LENGTH = 23;
	localparam int unsigned FIELD_W = 13;

	localparam logic [2:0] KIND_HEADER   = 3'd0;
	localparam logic [2:0] KIND_ID       = 3'd1;
	localparam logic [2:0] KIND_METHOD   = 3'd2;
	localparam logic [2:0] KIND_PAYLOAD  = 3'd3;
	localparam logic [2:0] KIND_TRAILER  = 3'd4;
	localparam logic [2:0] KIND_OVERFLOW = 3'd5;

	localparam logic REG_START_MARKER = 1'b0;
	localparam logic REG_END_MARKER   = 1'b1;

	typedef struct packed {
		logic       tick;
		logic [7:0] data;
	} cmd_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic [7:0]         data_byte;
		logic [7:0]         msg_type;
		logic [12:0]        frame_length;
		logic [12:0]        id_length;
		logic [12:0]        method_length;
		logic [12:0]        payload_length;
		logic signed [31:0] error_code;
		logic [31:0]        checksum;
		logic               frame_ok;
		logic               last;
	} res_t;

endpackage
`default_nettype wire

[rtl/core/rpcfd_front.sv]
`default_nettype none
module rpcfd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               command,
	input  logic [7:0]         in_byte,
	output logic               full,
	output logic               cmd_valid,
	output rpcfd_pkg::cmd_t    cmd,
	input  logic               cmd_pop
);
	import rpcfd_pkg::*;

	cmd_t       buf_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = buf_q[rd_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_q] <= '{tick: command, data: in_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= ~wr_q;
			if (do_pop) rd_q <= ~rd_q;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/core/rpcfd_back.sv]
`default_nettype none
module rpcfd_back #(
	parameter int unsigned STORE_DEPTH = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  rpcfd_pkg::cmd_t    cmd,
	output logic               cmd_pop,
	input  logic [7:0]         start_marker,
	input  logic [7:0]         end_marker,
	output logic               res_valid,
	output rpcfd_pkg::res_t    res,
	input  logic               res_pop
);
	import rpcfd_pkg::*;

	localparam int PTR_W = $clog2(STORE_DEPTH);
	localparam int CNT_W = $clog2(STORE_DEPTH + 1);
	localparam int SUM_W = PTR_W + 2;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STORE_DEPTH);
	localparam logic [CNT_W-1:0] MIN_C   = CNT_W'(MIN_FRAME_LENGTH);
	localparam logic [SUM_W-1:0] DEPTH_X = SUM_W'(STORE_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_READ  = 4'b0100,
		S_DRAIN = 4'b1000
	} state_t;

	typedef enum logic [8:0] {
		P_START = 9'b000000001,
		P_LEN   = 9'b000000010,
		P_END   = 9'b000000100,
		P_TYPE  = 9'b000001000,
		P_ILEN  = 9'b000010000,
		P_MLEN  = 9'b000100000,
		P_ERR   = 9'b001000000,
		P_CHK   = 9'b010000000,
		P_DATA  = 9'b100000000
	} step_t;

	logic [7:0]       mem_q [STORE_DEPTH];
	logic [7:0]       rdata_q;

	state_t           state_q;
	step_t            step_q;
	logic [CNT_W-1:0] off_q;
	logic [2:0]       cnt_q;
	logic [2:0]       n_q;
	logic [31:0]      acc_q;
	logic [PTR_W-1:0] rp_q;
	logic [PTR_W-1:0] wp_q;
	logic [CNT_W-1:0] fill_q;
	logic             drain_q;
	logic [CNT_W-1:0] dpos_q;
	logic [CNT_W-1:0] len_q;
	logic [CNT_W-1:0] ilen_q;
	logic [CNT_W-1:0] mlen_q;
	logic [7:0]       type_q;
	logic [31:0]      err_q;
	logic [31:0]      chk_q;
	logic [2:0]       dkind_q;
	logic             res_valid_q;
	res_t             res_q;

	logic [31:0]      acc_nx;
	logic [SUM_W-1:0] rd_sum;
	logic [PTR_W-1:0] rd_idx;
	logic             take;
	logic             wr_en;
	logic [CNT_W-1:0] room;
	logic             len_bad;
	logic             len_wait;
	logic             ilen_big;
	logic [32:0]      im_sum;
	logic             im_big;
	logic [CNT_W-1:0] acc_c;
	logic [CNT_W-1:0] b_id;
	logic [CNT_W-1:0] b_meth;
	logic [CNT_W-1:0] plen;

	function automatic logic [PTR_W-1:0] wrap(input logic [SUM_W-1:0] s);
		return (s >= DEPTH_X) ? PTR_W'(s - DEPTH_X) : PTR_W'(s);
	endfunction

	function automatic res_t mk_res(
		input logic [2:0]  k,
		input logic [7:0]  d,
		input logic [7:0]  t,
		input logic [12:0] fl,
		input logic [12:0] il,
		input logic [12:0] ml,
		input logic [12:0] pl,
		input logic [31:0] er,
		input logic [31:0] ck,
		input logic        ok,
		input logic        lst
	);
		res_t r;
		r.kind           = k;
		r.data_byte      = d;
		r.msg_type       = t;
		r.frame_length   = fl;
		r.id_length      = il;
		r.method_length  = ml;
		r.payload_length = pl;
		r.error_code     = er;
		r.checksum       = ck;
		r.frame_ok       = ok;
		r.last           = lst;
		return r;
	endfunction

	assign acc_nx   = {acc_q[23:0], rdata_q};
	assign acc_c    = CNT_W'(acc_nx);
	assign rd_sum   = SUM_W'(rp_q) + SUM_W'(off_q) + SUM_W'(cnt_q);
	assign rd_idx   = wrap(rd_sum);
	assign take     = (state_q == S_IDLE) && cmd_valid && !res_valid_q;
	assign cmd_pop  = take;
	assign wr_en    = take && !cmd.tick && (fill_q != DEPTH_C);
	assign room     = len_q - MIN_C;
	assign len_bad  = (acc_nx < 32'(MIN_FRAME_LENGTH)) || (acc_nx > 32'(STORE_DEPTH));
	assign len_wait = acc_nx > 32'(fill_q);
	assign ilen_big = acc_nx > 32'(room);
	assign im_sum   = 33'(ilen_q) + 33'(acc_nx);
	assign im_big   = im_sum > 33'(room);
	assign b_id     = ilen_q;
	assign b_meth   = ilen_q + mlen_q;
	assign plen     = room - ilen_q - mlen_q;

	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wp_q] <= cmd.data;
		end
		rdata_q <= mem_q[rd_idx];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			acc_q <= acc_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= P_START;
			off_q       <= '0;
			cnt_q       <= '0;
			n_q         <= '0;
			rp_q        <= '0;
			wp_q        <= '0;
			fill_q      <= '0;
			drain_q     <= 1'b0;
			dpos_q      <= '0;
			len_q       <= '0;
			ilen_q      <= '0;
			mlen_q      <= '0;
			type_q      <= '0;
			err_q       <= '0;
			chk_q       <= '0;
			dkind_q     <= KIND_ID;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (res_pop && res_valid_q) res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (take) begin
						if (!cmd.tick) begin
							if (fill_q == DEPTH_C) begin
								res_q <= mk_res(KIND_OVERFLOW, cmd.data, 8'd0, 13'd0,
									13'd0, 13'd0, 13'd0, 32'd0, 32'd0, 1'b0, 1'b0);
								res_valid_q <= 1'b1;
							end else begin
								wp_q   <= wrap(SUM_W'(wp_q) + SUM_W'(1));
								fill_q <= fill_q + CNT_W'(1);
							end
						end else begin
							state_q <= drain_q ? S_DRAIN : S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (fill_q == '0) begin
						state_q <= S_IDLE;
					end else begin
						off_q   <= '0;
						n_q     <= 3'd1;
						cnt_q   <= '0;
						step_q  <= P_START;
						state_q <= S_READ;
					end
				end
				S_DRAIN: begin
					cnt_q  <= '0;
					n_q    <= 3'd1;
					step_q <= P_DATA;
					if (dpos_q <= b_id) begin
						off_q   <= CNT_W'(9) + dpos_q;
						dkind_q <= KIND_ID;
						state_q <= S_READ;
					end else if (dpos_q <= b_meth) begin
						off_q   <= CNT_W'(13) + dpos_q;
						dkind_q <= KIND_METHOD;
						state_q <= S_READ;
					end else if (dpos_q <= room) begin
						off_q   <= CNT_W'(17) + dpos_q;
						dkind_q <= KIND_PAYLOAD;
						state_q <= S_READ;
					end else begin
						res_q <= mk_res(KIND_TRAILER, 8'd0, 8'd0, 13'd0, 13'd0, 13'd0,
							13'd0, 32'd0, chk_q, 1'b1, 1'b1);
						res_valid_q    <= 1'b1;
						rp_q           <= wrap(SUM_W'(rp_q) + SUM_W'(len_q));
						fill_q         <= fill_q - len_q;
						drain_q        <= 1'b0;
						dpos_q         <= '0;
						state_q        <= S_IDLE;
					end
				end
				S_READ: begin
					if (cnt_q == n_q) begin
						cnt_q <= '0;
						case (step_q)
							P_START: begin
								if (acc_nx[7:0] != start_marker) begin
									rp_q    <= wrap(SUM_W'(rp_q) + SUM_W'(1));
									fill_q  <= fill_q - CNT_W'(1);
									state_q <= S_SCAN;
								end else if (fill_q < CNT_W'(5)) begin
									state_q <= S_IDLE;
								end else begin
									off_q  <= CNT_W'(1);
									n_q    <= 3'd4;
									step_q <= P_LEN;
								end
							end
							P_LEN: begin
								if (len_bad) begin
									rp_q    <= wrap(SUM_W'(rp_q) + SUM_W'(1));
									fill_q  <= fill_q - CNT_W'(1);
									state_q <= S_SCAN;
								end else if (len_wait) begin
									state_q <= S_IDLE;
								end else begin
									len_q  <= acc_c;
									off_q  <= acc_c - CNT_W'(1);
									n_q    <= 3'd1;
									step_q <= P_END;
								end
							end
							P_END: begin
								if (acc_nx[7:0] != end_marker) begin
									rp_q    <= wrap(SUM_W'(rp_q) + SUM_W'(1));
									fill_q  <= fill_q - CNT_W'(1);
									state_q <= S_SCAN;
								end else begin
									off_q  <= CNT_W'(5);
									n_q    <= 3'd1;
									step_q <= P_TYPE;
								end
							end
							P_TYPE: begin
								type_q <= acc_nx[7:0];
								off_q  <= CNT_W'(6);
								n_q    <= 3'd4;
								step_q <= P_ILEN;
							end
							P_ILEN: begin
								if (ilen_big) begin
									res_q <= mk_res(KIND_HEADER, 8'd0, type_q,
										FIELD_W'(len_q), 13'd0, 13'd0, 13'd0, 32'd0,
										32'd0, 1'b0, 1'b1);
									res_valid_q <= 1'b1;
									rp_q   <= wrap(SUM_W'(rp_q) + SUM_W'(len_q));
									fill_q <= fill_q - len_q;
									state_q <= S_IDLE;
								end else begin
									ilen_q <= acc_c;
									off_q  <= CNT_W'(10) + acc_c;
									n_q    <= 3'd4;
									step_q <= P_MLEN;
								end
							end
							P_MLEN: begin
								if (im_big) begin
									res_q <= mk_res(KIND_HEADER, 8'd0, type_q,
										FIELD_W'(len_q), 13'd0, 13'd0, 13'd0, 32'd0,
										32'd0, 1'b0, 1'b1);
									res_valid_q <= 1'b1;
									rp_q   <= wrap(SUM_W'(rp_q) + SUM_W'(len_q));
									fill_q <= fill_q - len_q;
									state_q <= S_IDLE;
								end else begin
									mlen_q <= acc_c;
									off_q  <= CNT_W'(14) + ilen_q + acc_c;
									n_q    <= 3'd4;
									step_q <= P_ERR;
								end
							end
							P_ERR: begin
								err_q  <= acc_nx;
								off_q  <= len_q - CNT_W'(5);
								n_q    <= 3'd4;
								step_q <= P_CHK;
							end
							P_CHK: begin
								chk_q <= acc_nx;
								res_q <= mk_res(KIND_HEADER, 8'd0, type_q, FIELD_W'(len_q),
									FIELD_W'(ilen_q), FIELD_W'(mlen_q), FIELD_W'(plen),
									err_q, 32'd0, 1'b1, 1'b0);
								res_valid_q <= 1'b1;
								drain_q     <= 1'b1;
								dpos_q      <= CNT_W'(1);
								state_q     <= S_IDLE;
							end
							P_DATA: begin
								res_q <= mk_res(dkind_q, acc_nx[7:0], 8'd0, 13'd0, 13'd0,
									13'd0, 13'd0, 32'd0, 32'd0, 1'b1, 1'b0);
								res_valid_q <= 1'b1;
								dpos_q      <= dpos_q + CNT_W'(1);
								state_q     <= S_IDLE;
							end
							default: state_q <= S_IDLE;
						endcase
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/core/rpc_frame_deframer_unit.sv]
`default_nettype none
// channel   direction  handshake                     payload
// input     in         push / full                   command, in_byte
// result    out        empty / pop                   kind .. last
// config    in         psel, penable, pwrite, pready paddr, pwdata, prdata
//
// a stream byte passes through the input queue and is then written to the frame store by the back end
// a drain tick yields one id, method or payload byte, or else the trailer
// a hunt reads each header field through the single read port of the frame store,
// and after a rejected start it drops one byte and rescans
// reset clears pointers and counts and sets the markers to 2 and 3; the store itself is not cleared
// the input queue holds two transfers while the back end waits on an untaken result
module rpc_frame_deframer_unit #(
	parameter int unsigned STORE_DEPTH = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               command,
	input  logic [7:0]         in_byte,
	output logic               empty,
	input  logic               pop,
	output logic [2:0]         kind,
	output logic [7:0]         data_byte,
	output logic [7:0]         msg_type,
	output logic [12:0]        frame_length,
	output logic [12:0]        id_length,
	output logic [12:0]        method_length,
	output logic [12:0]        payload_length,
	output logic signed [31:0] error_code,
	output logic [31:0]        checksum,
	output logic               frame_ok,
	output logic               last,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import rpcfd_pkg::*;

	logic       cmd_valid;
	cmd_t       cmd;
	logic       cmd_pop;
	logic       res_valid;
	res_t       res;
	logic [7:0] start_q;
	logic [7:0] end_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 8'd2;
			end_q   <= 8'd3;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_START_MARKER: start_q <= pwdata[7:0];
				REG_END_MARKER:   end_q   <= pwdata[7:0];
				default:          start_q <= start_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_START_MARKER: prdata = {24'd0, start_q};
			REG_END_MARKER:   prdata = {24'd0, end_q};
			default:          prdata = '0;
		endcase
	end

	rpcfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.command   (command),
		.in_byte   (in_byte),
		.full      (full),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	rpcfd_back #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop),
		.start_marker (start_q),
		.end_marker   (end_q),
		.res_valid    (res_valid),
		.res          (res),
		.res_pop      (pop)
	);

	assign empty          = !res_valid;
	assign kind           = res.kind;
	assign data_byte      = res.data_byte;
	assign msg_type       = res.msg_type;
	assign frame_length   = res.frame_length;
	assign id_length      = res.id_length;
	assign method_length  = res.method_length;
	assign payload_length = res.payload_length;
	assign error_code     = res.error_code;
	assign checksum       = res.checksum;
	assign frame_ok       = res.frame_ok;
	assign last           = res.last;

endmodule
`default_nettype wire
